// File: rtl/recent_id_duplicate_filter_top_assert.svh
// assertion macros for the duplicate filter
`ifndef RECENT_ID_DUPLICATE_FILTER_TOP_ASSERT_SVH
`define RECENT_ID_DUPLICATE_FILTER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define RIDF_ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ridf: invariant violated");

// consequent holds in the cycle after the antecedent
`define RIDF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ridf: next-cycle check failed");

`endif

// File: rtl/ridf_pkg.sv
`timescale 1ns / 1ps

package ridf_pkg;

  localparam int ID_W    = 32;
  localparam int WSIZE_W = 11;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 11'd1024;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef logic [ID_W-1:0] id_t;

endpackage

// File: rtl/recent_id_duplicate_filter_top.sv
`timescale 1ns / 1ps
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------
// in       | in_valid / in_stall | in_packet_id [31:0]
// out      | out_valid/out_stall | out_is_duplicate
// cfg      | cfg_wr_en           | cfg_wr_data [10:0] window size
//
// a full scan runs from one input transfer to the next as follows:
// the window ring memory is read one entry per cycle from the oldest id, the
// last read is checked, then the result is handed off and input reopens.
// a match at the k-th entry stops the scan early.
// a new id adds a trim step and a ring write step before the hand-off.
// synchronous active-low reset empties the window and sets window size 1024.
// the finished result sits in an output register; out_stall holds it there
// while the next id is accepted and scanned.

`include "recent_id_duplicate_filter_top_assert.svh"

module recent_id_duplicate_filter_top #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ridf_pkg::WSIZE_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ridf_pkg::ID_W-1:0]     in_packet_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_duplicate
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int OW = $clog2(WINDOW_DEPTH + 1);
  localparam int CW = ((OW > ridf_pkg::WSIZE_W) ? OW : ridf_pkg::WSIZE_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(WINDOW_DEPTH - 1);

  ridf_pkg::state_t state_r, state_nxt;
  ridf_pkg::id_t    id_r, id_nxt;
  logic [ridf_pkg::WSIZE_W-1:0] wsize_r;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [OW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    raddr_r, raddr_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             dup_r, dup_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_dup_r, out_dup_nxt;

  logic             rd_en, wr_en;
  logic [AW-1:0]    wr_addr;
  ridf_pkg::id_t    rd_data;
  logic             hit;
  logic [OW-1:0]    eff;
  logic [CW-1:0]    wsize_ext;
  logic [OW-1:0]    delta;
  logic [AW:0]      trim_sum, ins_sum;
  logic [AW-1:0]    trim_ptr, ins_addr;

  ridf_ring #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (id_r),
    .rd_en   (rd_en),
    .rd_addr (raddr_r),
    .rd_data (rd_data)
  );

  // window size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= ridf_pkg::WSIZE_RESET;
    end else if (cfg_wr_en) begin
      wsize_r <= cfg_wr_data;
    end
  end

  // effective window, clamped to 1..depth
  assign wsize_ext = CW'(wsize_r);
  always_comb begin
    if (wsize_r == '0) begin
      eff = OW'(1);
    end else if (wsize_ext > DEPTH_C) begin
      eff = OW'(WINDOW_DEPTH);
    end else begin
      eff = OW'(wsize_ext);
    end
  end

  // ring arithmetic, sums stay below twice the depth
  assign delta    = occ_r - (eff - OW'(1));
  assign trim_sum = (AW + 1)'(ptr_r) + (AW + 1)'(delta);
  assign trim_ptr = (trim_sum >= (AW + 1)'(WINDOW_DEPTH)) ?
                    AW'(trim_sum - (AW + 1)'(WINDOW_DEPTH)) : AW'(trim_sum);
  assign ins_sum  = (AW + 1)'(ptr_r) + (AW + 1)'(occ_r);
  assign ins_addr = (ins_sum >= (AW + 1)'(WINDOW_DEPTH)) ?
                    AW'(ins_sum - (AW + 1)'(WINDOW_DEPTH)) : AW'(ins_sum);

  assign hit = rd_pend_r && (rd_data == id_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ridf_pkg::ST_IDLE;
      ptr_r       <= '0;
      occ_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      occ_r       <= occ_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    cnt_r     <= cnt_nxt;
    raddr_r   <= raddr_nxt;
    dup_r     <= dup_nxt;
    out_dup_r <= out_dup_nxt;
  end

  // sequencer: scan, trim, write, hand off result
  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    ptr_nxt       = ptr_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    raddr_nxt     = raddr_r;
    rd_pend_nxt   = 1'b0;
    dup_nxt       = dup_r;
    out_dup_nxt   = out_dup_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = ins_addr;
    in_stall      = 1'b1;
    case (state_r)
      ridf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          id_nxt    = in_packet_id;
          cnt_nxt   = '0;
          raddr_nxt = ptr_r;
          state_nxt = ridf_pkg::ST_SCAN;
        end
      end
      ridf_pkg::ST_SCAN: begin
        if (hit) begin
          dup_nxt   = 1'b1;
          state_nxt = ridf_pkg::ST_DONE;
        end else if (cnt_r == occ_r) begin
          state_nxt = ridf_pkg::ST_TRIM;
        end else begin
          rd_en       = 1'b1;
          rd_pend_nxt = 1'b1;
          cnt_nxt     = cnt_r + OW'(1);
          raddr_nxt   = (raddr_r == LAST_A) ? '0 : raddr_r + AW'(1);
        end
      end
      ridf_pkg::ST_TRIM: begin
        if (occ_r >= eff) begin
          ptr_nxt = trim_ptr;
          occ_nxt = eff - OW'(1);
        end
        state_nxt = ridf_pkg::ST_WRITE;
      end
      ridf_pkg::ST_WRITE: begin
        wr_en     = 1'b1;
        occ_nxt   = occ_r + OW'(1);
        dup_nxt   = 1'b0;
        state_nxt = ridf_pkg::ST_DONE;
      end
      ridf_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dup_nxt   = dup_r;
          state_nxt     = ridf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ridf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_is_duplicate = out_dup_r;

  // checks
  `RIDF_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, (occ_r <= OW'(WINDOW_DEPTH)))
  `RIDF_ASSERT_ALWAYS(a_scan_bound, clk, rst_n,
    (state_r != ridf_pkg::ST_SCAN) || (cnt_r <= occ_r))
  `RIDF_ASSERT_NEXT(a_accept_busy, clk, rst_n, (in_valid && !in_stall),
    (state_r == ridf_pkg::ST_SCAN))
  `RIDF_ASSERT_NEXT(a_write_grows, clk, rst_n, wr_en,
    (occ_r == $past(occ_r) + OW'(1)) && (occ_r <= OW'(WINDOW_DEPTH)))

endmodule

// File: rtl/ridf_ring.sv
`timescale 1ns / 1ps

module ridf_ring #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  ridf_pkg::id_t    wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output ridf_pkg::id_t    rd_data
);

  ridf_pkg::id_t mem [DEPTH];
  ridf_pkg::id_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: verif/recent_id_duplicate_filter_top_tb.sv
`timescale 1ns / 1ps

module recent_id_duplicate_filter_top_tb;

  localparam int DEPTH        = 1024;
  localparam int IDLE_LIMIT   = 6000;
  localparam int RANDOM_ITEMS = 400;
  localparam int FILL_ITEMS   = 120;
  localparam int PROBE_ITEMS  = 24;
  localparam int RECENT_KEEP  = 48;
  localparam int TAIL_CYCLES  = 1100;

  typedef logic [ridf_pkg::WSIZE_W-1:0] wsize_t;

  typedef struct {
    ridf_pkg::id_t id;
    bit            dup;
  } verdict_t;

  // window predictor plus the queue of verdicts still owed by the block
  class dup_verdict_board;
    ridf_pkg::id_t ring [DEPTH];
    int unsigned   oldest;
    int unsigned   held;
    wsize_t        window_reg;
    verdict_t      pending_q[$];
    int            mismatches;

    function new();
      oldest     = 0;
      held       = 0;
      window_reg = ridf_pkg::WSIZE_RESET;
      mismatches = 0;
    endfunction

    function void set_window(wsize_t value);
      window_reg = value;
    endfunction

    // zero acts as one, anything past the ring depth saturates
    function int unsigned effective_window();
      if (window_reg == 0) return 1;
      if (window_reg > DEPTH) return DEPTH;
      return window_reg;
    endfunction

    function bit window_holds(ridf_pkg::id_t id);
      for (int unsigned k = 0; k < held; k++) begin
        if (ring[(oldest + k) % DEPTH] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    // accepted id: work out the verdict and update the window
    function void note_packet(ridf_pkg::id_t id);
      verdict_t    v;
      int unsigned lim;
      v.id  = id;
      v.dup = window_holds(id);
      if (!v.dup) begin
        lim = effective_window();
        // evict oldest ids until there is room, trims a lowered window
        while (held >= lim) begin
          oldest = (oldest + 1) % DEPTH;
          held--;
        end
        ring[(oldest + held) % DEPTH] = id;
        held++;
      end
      pending_q = {pending_q, v};
    endfunction

    function void check_verdict(logic got);
      verdict_t v;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got is_duplicate=%0b", $time, got);
        mismatches++;
        return;
      end
      v = pending_q.pop_front();
      if (got !== v.dup) begin
        $display("%0t: id %h is_duplicate expected %0b, got %0b", $time, v.id, v.dup, got);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n        = 1'b0;
  logic          cfg_wr_en    = 1'b0;
  wsize_t        cfg_wr_data  = '0;
  logic          in_valid     = 1'b0;
  logic          in_stall;
  ridf_pkg::id_t in_packet_id = '0;
  logic          out_valid;
  logic          out_stall    = 1'b0;
  logic          out_is_duplicate;

  dup_verdict_board verdicts;
  ridf_pkg::id_t    recent_q[$];
  int               burst_left   = 0;
  int               quiet_cycles = 0;
  int               stall_left   = 0;
  int               stall_mode   = 0;
  int               mode_left    = 0;

  recent_id_duplicate_filter_top #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_packet_id    (in_packet_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_duplicate(out_is_duplicate)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitor both channels and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) verdicts.note_packet(in_packet_id);
      if (out_valid && !out_stall) verdicts.check_verdict(out_is_duplicate);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // receiver stall pattern: none, short random stalls, or long stalls
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 400);
    end
    mode_left--;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      case (stall_mode)
        1: begin
          if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
        end
        2: begin
          if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 20);
        end
        default: begin
          stall_left = 0;
        end
      endcase
    end
    out_stall <= (stall_left > 0);
  end

  // one id transfer, sender works in bursts with gaps between them
  task automatic send_packet(input ridf_pkg::id_t id);
    if (burst_left == 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid     <= 1'b1;
    in_packet_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    recent_q = {recent_q, id};
    if (recent_q.size() > RECENT_KEEP) void'(recent_q.pop_front());
  endtask

  // hold off the sender until every verdict is back
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (verdicts.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input wsize_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    verdicts.set_window(value);
  endtask

  // mostly small windows, with zero, reset size and oversize now and then
  function automatic wsize_t pick_window();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return ridf_pkg::WSIZE_RESET;
      2: return wsize_t'($urandom_range(DEPTH + 1, 2047));
      3, 4: return wsize_t'($urandom_range(17, 64));
      default: return wsize_t'($urandom_range(1, 16));
    endcase
  endfunction

  // repeats of recent ids, small ids that collide, extremes, full random
  function automatic ridf_pkg::id_t pick_packet_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && recent_q.size() != 0) return recent_q[$urandom_range(0, recent_q.size() - 1)];
    if (r < 55) return $urandom_range(0, 15);
    if (r < 60) return r[0] ? '1 : '0;
    return $urandom;
  endfunction

  initial begin
    ridf_pkg::id_t edge_ids [6];
    ridf_pkg::id_t early_q[$];
    ridf_pkg::id_t id;
    int            random_sent;
    int            n;

    edge_ids    = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    random_sent = 0;
    verdicts    = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window: extreme ids, all-zero and all-one each seen twice
    foreach (edge_ids[i]) send_packet(edge_ids[i]);

    // window size zero holds only the last id
    wait_drained();
    write_window('0);
    send_packet(32'd7);
    send_packet(32'd7);
    send_packet(32'd8);
    send_packet(32'd7);

    wait_drained();
    write_window(11'd8);
    for (int i = 100; i < 106; i++) send_packet(i);

    // lowered window is trimmed on the next insert
    wait_drained();
    write_window(11'd2);
    send_packet(32'd200);
    send_packet(32'd105);
    send_packet(32'd104);

    // oversize window
    wait_drained();
    write_window(11'd2047);
    send_packet(32'd105);
    send_packet(32'd300);

    // random phases with random window sizes
    while (random_sent < RANDOM_ITEMS) begin
      wait_drained();
      write_window(pick_window());
      n = $urandom_range(15, 50);
      repeat (n) send_packet(pick_packet_id());
      random_sent += n;
    end

    // oversize window saturates at the ring depth while it fills
    wait_drained();
    write_window(11'd2047);
    for (int i = 0; i < FILL_ITEMS; i++) begin
      if (i % 16 == 15) id = recent_q[$urandom_range(0, recent_q.size() - 1)];
      else id = $urandom;
      if (i < PROBE_ITEMS) early_q = {early_q, id};
      send_packet(id);
    end
    // probe early fill ids and recent ids
    for (int i = 0; i < PROBE_ITEMS; i++) begin
      if (i % 2 == 0) send_packet(early_q[i / 2]);
      else send_packet(recent_q[$urandom_range(0, recent_q.size() - 1)]);
    end

    // large window trimmed down to a small one
    wait_drained();
    write_window(11'd3);
    repeat (12) send_packet(pick_packet_id());

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdicts.mismatches == 0 && verdicts.pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: recent_id_duplicate_filter_top.f
+incdir+rtl
rtl/ridf_pkg.sv
rtl/ridf_ring.sv
rtl/recent_id_duplicate_filter_top.sv
verif/recent_id_duplicate_filter_top_tb.sv
